// ===== rtl/core/frv_pkg.sv =====
// Package for the flow record validator: item types, verdict codes, constants.
// Used by every module of the block; depends on nothing.
package frv_pkg;

  localparam int TIME_BITS    = 32;
  localparam int COUNTER_BITS = 32;
  localparam int BYTE_BITS    = 48;
  localparam int PKT_BITS     = 40;
  localparam int DUR_BITS     = 10;
  localparam int NUM_CNT      = 6;

  localparam logic [TIME_BITS-1:0] MAX_DURATION = TIME_BITS'(600);
  localparam logic [BYTE_BITS-1:0] MIN_BYTES     = BYTE_BITS'(20);
  localparam logic [BYTE_BITS-1:0] MIN_TCP_BYTES = BYTE_BITS'(40);
  localparam logic [7:0]           TCP_PROTO     = 8'd6;
  // floor(b/p) > 9216 exactly when b >= 9217*p.
  localparam logic [13:0] MTU_LIMIT   = 14'd9217;
  // floor(floor(b/125000)/d) > 10000 exactly when b >= 125000*10001*d.
  localparam logic [30:0] BRATE_LIMIT = 31'd1250125000;
  // floor(floor(p/1000)/d) > 10000 exactly when p >= 1000*10001*d.
  localparam logic [23:0] PRATE_LIMIT = 24'd10001000;

  localparam logic [TIME_BITS-1:0] INTERVAL_RESET = TIME_BITS'(300);
  localparam logic [TIME_BITS-1:0] WINDOW_RESET   = TIME_BITS'(600);

  localparam logic [7:0] REG_STAT_INTERVAL = 8'd0;
  localparam logic [7:0] REG_WINDOW        = 8'd1;

  localparam int C_ACC   = 0;
  localparam int C_FRESH = 1;
  localparam int C_CAUS  = 2;
  localparam int C_BYTES = 3;
  localparam int C_PKTS  = 4;
  localparam int C_MTU   = 5;

  typedef enum logic [3:0] {
    V_ACCEPT   = 4'd0,
    V_SKIPPED  = 4'd1,
    V_CAUSAL   = 4'd2,
    V_BACKWARD = 4'd3,
    V_FORWARD  = 4'd4,
    V_ZERO_PKT = 4'd5,
    V_BYTES    = 4'd6,
    V_MTU      = 4'd7,
    V_BITRATE  = 4'd8,
    V_PKTRATE  = 4'd9
  } verdict_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } back_state_t;

  typedef struct packed {
    logic                 rec_valid;
    logic                 causal_bad;
    logic [TIME_BITS-1:0] stop;
    logic                 zero_pkt;
    logic                 few_bytes;
    logic                 mtu_bad;
    logic                 brate_bad;
    logic                 prate_bad;
  } frv_item_t;

  typedef logic [COUNTER_BITS-1:0] counter_t;

endpackage

// ===== rtl/core/frv_front.sv =====
// Front part: classifies each record with all checks that need no state.
// Depends on frv_pkg.
module frv_front (
  input  logic                          record_valid,
  input  logic [frv_pkg::TIME_BITS-1:0] start_time,
  input  logic [frv_pkg::TIME_BITS-1:0] stop_time,
  input  logic [frv_pkg::PKT_BITS-1:0]  packet_count,
  input  logic [frv_pkg::BYTE_BITS-1:0] byte_count,
  input  logic [7:0]                    ip_protocol,
  output frv_pkg::frv_item_t            item
);
  import frv_pkg::*;

  logic [TIME_BITS-1:0] dur;
  logic [DUR_BITS-1:0]  dlen;
  logic [53:0]          mtu_prod;
  logic [40:0]          brate_prod;
  logic [33:0]          prate_prod;

  always_comb begin
    dur = stop_time - start_time;
    dlen = (dur[DUR_BITS-1:0] == '0) ? DUR_BITS'(1) : dur[DUR_BITS-1:0];
    mtu_prod = packet_count * MTU_LIMIT;
    brate_prod = BRATE_LIMIT * dlen;
    prate_prod = PRATE_LIMIT * dlen;
    item.rec_valid = record_valid;
    item.causal_bad = (stop_time < start_time) || (dur > MAX_DURATION);
    item.stop = stop_time;
    item.zero_pkt = (packet_count == '0);
    item.few_bytes = (byte_count < MIN_BYTES) ||
                     ((ip_protocol == TCP_PROTO) && (byte_count < MIN_TCP_BYTES));
    item.mtu_bad = {6'd0, byte_count} >= mtu_prod;
    item.brate_bad = byte_count >= {7'd0, brate_prod};
    item.prate_bad = {6'd0, packet_count} >= {12'd0, prate_prod};
  end

endmodule

// ===== rtl/core/frv_queue.sv =====
// Two-entry queue of classified items between the front and back parts.
// Depends on frv_pkg.
module frv_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  frv_pkg::frv_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output frv_pkg::frv_item_t head
);
  import frv_pkg::*;

  frv_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/frv_div.sv =====
// Restoring divider giving the remainder, one quotient bit per cycle.
// Depends on frv_pkg.
module frv_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [frv_pkg::TIME_BITS-1:0] dividend,
  input  logic [frv_pkg::TIME_BITS-1:0] divisor,
  output logic                          done,
  output logic [frv_pkg::TIME_BITS-1:0] rem
);
  import frv_pkg::*;

  localparam int CNT_W = $clog2(TIME_BITS);

  logic [TIME_BITS-1:0] shifter;
  logic [TIME_BITS-1:0] dvs;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [TIME_BITS:0]   trial;

  assign trial = {rem, shifter[TIME_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shifter <= dividend;
      dvs <= divisor;
      rem <= '0;
      cnt <= CNT_W'(TIME_BITS - 1);
    end else if (busy) begin
      shifter <= {shifter[TIME_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
      if (trial >= {1'b0, dvs}) begin
        rem <= TIME_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[TIME_BITS-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/frv_back.sv =====
// Back part: time window, statistics intervals, counters and the result register.
// Depends on frv_pkg and frv_div.
module frv_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [frv_pkg::TIME_BITS-1:0] stat_interval,
  input  logic [frv_pkg::TIME_BITS-1:0] window,
  input  logic                          q_valid,
  input  frv_pkg::frv_item_t            q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    verdict,
  output logic                          stat_valid,
  output logic [31:0]                   stat_start,
  output logic [31:0]                   stat_duration,
  output logic [31:0]                   stat_accepted,
  output logic [31:0]                   stat_freshness,
  output logic [31:0]                   stat_causality,
  output logic [31:0]                   stat_bytes,
  output logic [31:0]                   stat_packets,
  output logic [31:0]                   stat_mtu
);
  import frv_pkg::*;

  back_state_t          state, state_next;
  logic [TIME_BITS-1:0] current_time, current_time_next;
  logic [TIME_BITS-1:0] last_jump_time, last_jump_time_next;
  logic [TIME_BITS:0]   next_export_time, next_export_time_next;
  logic [TIME_BITS-1:0] interval_start, interval_start_next;
  counter_t             counters [NUM_CNT];
  counter_t             counters_next [NUM_CNT];

  logic                 out_free;
  logic                 load;
  verdict_t             v_next;
  logic                 export_hit;
  logic [TIME_BITS-1:0] iv;
  logic [TIME_BITS-1:0] d_cur;
  logic [TIME_BITS-1:0] d_jump;
  logic                 div_done;
  logic [TIME_BITS-1:0] div_rem;
  logic [TIME_BITS-1:0] export_stop;

  assign out_free = !out_valid || out_ready;
  assign iv = (stat_interval == '0) ? TIME_BITS'(1) : stat_interval;

  frv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (load && export_hit),
    .dividend (q_item.stop),
    .divisor  (iv),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_next = state;
    current_time_next = current_time;
    last_jump_time_next = last_jump_time;
    next_export_time_next = next_export_time;
    interval_start_next = interval_start;
    counters_next = counters;
    q_pop = 1'b0;
    load = 1'b0;
    v_next = V_SKIPPED;
    export_hit = 1'b0;
    d_cur = (q_item.stop > current_time) ? q_item.stop - current_time
                                         : current_time - q_item.stop;
    d_jump = (q_item.stop > last_jump_time) ? q_item.stop - last_jump_time
                                            : last_jump_time - q_item.stop;
    case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          load = 1'b1;
          if (!q_item.rec_valid) begin
            v_next = V_SKIPPED;
          end else if (q_item.causal_bad) begin
            v_next = V_CAUSAL;
            if (counters[C_CAUS] != '1) counters_next[C_CAUS] = counters[C_CAUS] + 1'b1;
          end else if (d_cur > window && current_time != '0 &&
                       q_item.stop < current_time) begin
            v_next = V_BACKWARD;
            if (counters[C_FRESH] != '1) counters_next[C_FRESH] = counters[C_FRESH] + 1'b1;
          end else if (d_cur > window && current_time != '0 && d_jump > window) begin
            v_next = V_FORWARD;
            last_jump_time_next = q_item.stop;
            if (counters[C_FRESH] != '1) counters_next[C_FRESH] = counters[C_FRESH] + 1'b1;
          end else begin
            if (d_cur > window && current_time == '0) begin
              last_jump_time_next = q_item.stop;
            end
            current_time_next = q_item.stop;
            if ({1'b0, q_item.stop} >= next_export_time) begin
              export_hit = 1'b1;
              interval_start_next = q_item.stop;
              for (int i = 0; i < NUM_CNT; i++) begin
                counters_next[i] = '0;
              end
              state_next = BK_DIV;
            end
            if (q_item.zero_pkt) begin
              v_next = V_ZERO_PKT;
              counters_next[C_PKTS] = (counters_next[C_PKTS] != '1) ?
                                      counters_next[C_PKTS] + 1'b1 : counters_next[C_PKTS];
            end else if (q_item.few_bytes) begin
              v_next = V_BYTES;
              counters_next[C_BYTES] = (counters_next[C_BYTES] != '1) ?
                                       counters_next[C_BYTES] + 1'b1 : counters_next[C_BYTES];
            end else if (q_item.mtu_bad) begin
              v_next = V_MTU;
              counters_next[C_MTU] = (counters_next[C_MTU] != '1) ?
                                     counters_next[C_MTU] + 1'b1 : counters_next[C_MTU];
            end else if (q_item.brate_bad) begin
              v_next = V_BITRATE;
            end else if (q_item.prate_bad) begin
              v_next = V_PKTRATE;
            end else begin
              v_next = V_ACCEPT;
              counters_next[C_ACC] = (counters_next[C_ACC] != '1) ?
                                     counters_next[C_ACC] + 1'b1 : counters_next[C_ACC];
            end
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          next_export_time_next = {1'b0, export_stop} - {1'b0, div_rem} + {1'b0, iv};
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      current_time <= '0;
      last_jump_time <= '0;
      next_export_time <= '0;
      interval_start <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        counters[i] <= '0;
      end
    end else begin
      state <= state_next;
      current_time <= current_time_next;
      last_jump_time <= last_jump_time_next;
      next_export_time <= next_export_time_next;
      interval_start <= interval_start_next;
      counters <= counters_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      export_stop <= q_item.stop;
      verdict <= v_next;
      stat_valid <= export_hit && (interval_start != '0);
      if (export_hit && (interval_start != '0)) begin
        stat_start <= interval_start;
        stat_duration <= q_item.stop - interval_start;
        stat_accepted <= counters[C_ACC];
        stat_freshness <= counters[C_FRESH];
        stat_causality <= counters[C_CAUS];
        stat_bytes <= counters[C_BYTES];
        stat_packets <= counters[C_PKTS];
        stat_mtu <= counters[C_MTU];
      end else begin
        stat_start <= '0;
        stat_duration <= '0;
        stat_accepted <= '0;
        stat_freshness <= '0;
        stat_causality <= '0;
        stat_bytes <= '0;
        stat_packets <= '0;
        stat_mtu <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/flow_record_validator.sv =====
// Top level of the flow record validator: configuration registers and the
// front, queue and back parts. Depends on frv_pkg, frv_front, frv_queue, frv_back.
//
//   Channel  Handshake               Carries
//   in       in_valid / in_ready     one flow record
//   out      out_valid / out_ready   verdict and statistics record
//   cfg      cfg_valid / cfg_ready   register index and data
//
// An ordinary record passes the back part without a stall, so records flow at one
// per cycle while out_ready is high. A record that crosses an interval boundary
// holds the back part while the 32-step remainder divider finds the next
// boundary; its result is given at once. The two-entry queue lets the front keep
// accepting until it fills during such a stall. Reset restores both registers.
module flow_record_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        record_valid,
  input  logic [31:0] start_time,
  input  logic [31:0] stop_time,
  input  logic [39:0] packet_count,
  input  logic [47:0] byte_count,
  input  logic [7:0]  ip_protocol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  verdict,
  output logic        stat_valid,
  output logic [31:0] stat_start,
  output logic [31:0] stat_duration,
  output logic [31:0] stat_accepted,
  output logic [31:0] stat_freshness,
  output logic [31:0] stat_causality,
  output logic [31:0] stat_bytes,
  output logic [31:0] stat_packets,
  output logic [31:0] stat_mtu,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import frv_pkg::*;

  logic [TIME_BITS-1:0] export_period;
  logic [TIME_BITS-1:0] window_len;
  frv_item_t            front_item;
  frv_item_t            q_head;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;

  assign in_ready = !q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      export_period <= INTERVAL_RESET;
      window_len <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STAT_INTERVAL) begin
        export_period <= cfg_data;
      end else if (cfg_index == REG_WINDOW) begin
        window_len <= cfg_data;
      end
    end
  end

  frv_front u_front (
    .record_valid (record_valid),
    .start_time   (start_time),
    .stop_time    (stop_time),
    .packet_count (packet_count),
    .byte_count   (byte_count),
    .ip_protocol  (ip_protocol),
    .item         (front_item)
  );

  frv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  frv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .stat_interval  (export_period),
    .window         (window_len),
    .q_valid        (q_valid),
    .q_item         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .stat_valid     (stat_valid),
    .stat_start     (stat_start),
    .stat_duration  (stat_duration),
    .stat_accepted  (stat_accepted),
    .stat_freshness (stat_freshness),
    .stat_causality (stat_causality),
    .stat_bytes     (stat_bytes),
    .stat_packets   (stat_packets),
    .stat_mtu       (stat_mtu)
  );

endmodule
